// ===== rtl/core/trk2_pkg.sv =====
// Shared types and constants for the track-2 sentinel and LRC checker.
// Used by trk2_decode, trk2_result_reg and track2_sentinel_lrc_checker.
package trk2_pkg;

  localparam logic [7:0] CH_START = 8'h3B;  // ';'
  localparam logic [7:0] CH_END   = 8'h3F;  // '?'
  localparam logic [7:0] CH_SEP   = 8'h3D;  // '='
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Configuration register indexes
  localparam logic CFG_CHECK_LRC    = 1'b0;
  localparam logic CFG_PARITY_FAULT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_NO_START  = 3'd1,
    VERDICT_NO_END    = 3'd2,
    VERDICT_LRC_BAD   = 3'd3,
    VERDICT_EMPTY_ACC = 3'd4,
    VERDICT_ILLEGAL   = 3'd5,
    VERDICT_PARITY    = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_AFTER   = 3'b100
  } phase_t;

  typedef struct packed {
    logic check_lrc;
    logic parity_fault;
  } cfg_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_char;
    logic       account_part;
    logic       track_done;
    verdict_t   verdict;
    logic       reversed_swipe;
  } result_t;

endpackage

// ===== rtl/core/track2_sentinel_lrc_checker.sv =====
// Track-2 sentinel and LRC checker, top level.
// Depends on trk2_pkg, trk2_decode and trk2_result_reg.
//
// Usage: one ASCII track character per item enters on in_tdata, with in_tlast
// on the last character of a track. Every item gives one result item: payload
// characters between the first ';' and the first '?' appear with tuser[0] set,
// and tuser[1] marks those before the first '='. The result of the last
// character carries out_tlast, the verdict and the reverse-swipe flag; the
// track state then clears for the next track. A consumer drops the payload
// when the verdict is not zero.
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle, set by the input register and the result
// register, which are both loaded every cycle when the output is taken.
// When the receiver stalls, the result register holds, the input register
// fills and in_tready falls; nothing is lost. Reset (rst_n low, synchronous)
// empties both registers, clears the track state and sets check_lrc to 1 and
// parity_fault to 0. The cfg_ port writes a register at each clock
// edge with cfg_we high; write it only while no track item is in flight.
module track2_sentinel_lrc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] track_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_char, [10:8] verdict,
                                  // [11] reversed_swipe, [15:12] zero
  output logic [1:0]  out_tuser,  // [0] payload_valid, [1] account_part
  output logic        out_tlast,  // track_done
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic        cfg_wdata
);

  trk2_pkg::cfg_t    cfg_r;
  trk2_pkg::result_t dec_res;
  trk2_pkg::result_t out_res;
  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_fin_r;
  logic              res_load_ready;
  logic              item_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_lrc    <= 1'b1;
      cfg_r.parity_fault <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        trk2_pkg::CFG_CHECK_LRC:    cfg_r.check_lrc    <= cfg_wdata;
        trk2_pkg::CFG_PARITY_FAULT: cfg_r.parity_fault <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item_adv  = in_valid_r && res_load_ready;
  assign in_tready = !in_valid_r || res_load_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_fin_r  <= in_tlast;
    end
  end

  trk2_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_adv  (item_adv),
    .item_byte (in_byte_r),
    .item_fin  (in_fin_r),
    .cfg       (cfg_r),
    .res       (dec_res)
  );

  trk2_result_reg u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_valid_r),
    .load_res   (dec_res),
    .load_ready (res_load_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (out_res)
  );

  assign out_tdata = {4'b0000, out_res.reversed_swipe, out_res.verdict,
                      out_res.payload_char};
  assign out_tuser = {out_res.account_part, out_res.payload_valid};
  assign out_tlast = out_res.track_done;

  // A verdict only comes with the last item of a track
  a_verdict_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.verdict != trk2_pkg::VERDICT_OK) |-> out_res.track_done)
    else $error("verdict set on a result that is not the last of its track");

  // Account marking only on payload, and non-payload carries a zero character
  a_account_in_payload : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_res.payload_valid |->
      !out_res.account_part && (out_res.payload_char == 8'h00))
    else $error("account mark or character on a non-payload result");

  // A reverse swipe is reported only with a missing start sentinel
  a_reverse_no_start : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.reversed_swipe |->
      out_res.verdict == trk2_pkg::VERDICT_NO_START)
    else $error("reverse swipe without a no-start verdict");

  // A waiting input item stays put while the result side is blocked
  a_input_hold : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !res_load_ready |=> in_valid_r && $stable(in_byte_r) && $stable(in_fin_r))
    else $error("input register changed while blocked");

endmodule

// ===== rtl/core/trk2_decode.sv =====
// Track state registers and per-item decode: sentinel phase, running XOR,
// flags and the final verdict. Depends on trk2_pkg.
module trk2_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_adv,
  input  logic [7:0]        item_byte,
  input  logic              item_fin,
  input  trk2_pkg::cfg_t    cfg,
  output trk2_pkg::result_t res
);

  trk2_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       ebs_r, ebs_nxt;
  logic       sep_r, sep_nxt;
  logic       acc_r, acc_nxt;
  logic       bad_r, bad_nxt;
  logic       open_r;
  logic       is_body;

  always_comb begin
    is_body   = !(item_fin && cfg.check_lrc && open_r);
    xor_nxt   = xor_r ^ item_byte;
    phase_nxt = phase_r;
    ebs_nxt   = ebs_r;
    sep_nxt   = sep_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    res       = '0;

    if (is_body) begin
      unique case (phase_r)
        trk2_pkg::PH_SEARCH: begin
          if (item_byte == trk2_pkg::CH_START) begin
            phase_nxt = trk2_pkg::PH_PAYLOAD;
          end else if (item_byte == trk2_pkg::CH_END) begin
            ebs_nxt = 1'b1;
          end
        end
        trk2_pkg::PH_PAYLOAD: begin
          if (item_byte == trk2_pkg::CH_END) begin
            phase_nxt = trk2_pkg::PH_AFTER;
          end else begin
            res.payload_valid = 1'b1;
            res.payload_char  = item_byte;
            if (item_byte == trk2_pkg::CH_SEP) begin
              sep_nxt = 1'b1;
            end else begin
              if (!sep_r) begin
                res.account_part = 1'b1;
                acc_nxt          = 1'b1;
              end
              if (item_byte < trk2_pkg::CH_ZERO || item_byte > trk2_pkg::CH_NINE) begin
                bad_nxt = 1'b1;
              end
            end
          end
        end
        default: ;  // after end sentinel: XOR only
      endcase
    end

    if (item_fin) begin
      res.track_done = 1'b1;
      if (cfg.check_lrc && xor_nxt != 8'h00) begin
        res.verdict = trk2_pkg::VERDICT_LRC_BAD;
      end else if (phase_nxt == trk2_pkg::PH_SEARCH) begin
        res.verdict        = trk2_pkg::VERDICT_NO_START;
        res.reversed_swipe = ebs_nxt;
      end else if (ebs_nxt || phase_nxt == trk2_pkg::PH_PAYLOAD) begin
        res.verdict = trk2_pkg::VERDICT_NO_END;
      end else if (!acc_nxt) begin
        res.verdict = trk2_pkg::VERDICT_EMPTY_ACC;
      end else if (bad_nxt) begin
        res.verdict = trk2_pkg::VERDICT_ILLEGAL;
      end else if (cfg.parity_fault) begin
        res.verdict = trk2_pkg::VERDICT_PARITY;
      end else begin
        res.verdict = trk2_pkg::VERDICT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= trk2_pkg::PH_SEARCH;
      xor_r   <= '0;
      ebs_r   <= 1'b0;
      sep_r   <= 1'b0;
      acc_r   <= 1'b0;
      bad_r   <= 1'b0;
      open_r  <= 1'b0;
    end else if (item_adv) begin
      if (item_fin) begin
        // clear for the next track
        phase_r <= trk2_pkg::PH_SEARCH;
        xor_r   <= '0;
        ebs_r   <= 1'b0;
        sep_r   <= 1'b0;
        acc_r   <= 1'b0;
        bad_r   <= 1'b0;
        open_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        ebs_r   <= ebs_nxt;
        sep_r   <= sep_nxt;
        acc_r   <= acc_nxt;
        bad_r   <= bad_nxt;
        open_r  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/trk2_result_reg.sv =====
// Result register in front of the output channel; takes a new item whenever
// it is empty or its item is being taken. Depends on trk2_pkg.
module trk2_result_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  trk2_pkg::result_t load_res,
  output logic              load_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output trk2_pkg::result_t res
);

  logic              valid_r;
  trk2_pkg::result_t res_r;

  assign load_ready = !valid_r || res_ready;
  assign res_valid  = valid_r;
  assign res        = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      res_r <= load_res;
    end
  end

endmodule
